// ===== design/arithmetic_range_encoder_assert.svh =====
// Assertion macros for the arithmetic range encoder.
// Included by the top level; expects clk and rst in scope.
`ifndef ARITHMETIC_RANGE_ENCODER_ASSERT_SVH
`define ARITHMETIC_RANGE_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ARE_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/are_pkg.sv =====
// Shared constants for the arithmetic range encoder.
// Used by the channel interfaces and the top level; no dependencies.
package are_pkg;

  localparam int FREQ_W      = 14;
  localparam int CODE_W      = 16;
  localparam int WORD_BITS   = 32;
  localparam int POS_W       = $clog2(WORD_BITS);
  localparam int BYTES_W     = 3;
  localparam int STATUS_W    = 2;
  localparam int MAX_RESULTS = 10;
  localparam int RES_W       = 4;
  localparam int Q_W         = CODE_W + 1;
  localparam int DIV_STEPS   = Q_W;
  localparam int PROD_W      = 32;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

endpackage

// ===== design/are_if.sv =====
// Valid/ready channel interfaces for encoder requests and code words.
// Depends on are_pkg for the field widths.
interface are_item_if import are_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [FREQ_W-1:0] cum_freq;
  logic [FREQ_W-1:0] sym_freq;
  logic [FREQ_W-1:0] total_freq;

  modport source (output valid, req_type, cum_freq, sym_freq, total_freq, input ready);
  modport sink (input valid, req_type, cum_freq, sym_freq, total_freq, output ready);
endinterface

interface are_result_if import are_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] out_word;
  logic [BYTES_W-1:0]   valid_bytes;
  logic                 last_of_run;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, out_word, valid_bytes, last_of_run, status, input ready);
  modport sink (input valid, out_word, valid_bytes, last_of_run, status, output ready);
endinterface

// ===== design/arithmetic_range_encoder.sv =====
// 16-bit arithmetic encoder with a bit-serial renormalizer and word packer.
// Depends on are_pkg, are_if.sv and arithmetic_range_encoder_assert.svh.
//
// The encoder takes one request at a time. A flush or a request with bad
// frequencies goes through a response state that loads the output register
// once it is free. An encode request forms the two interval products in turn,
// runs a serial restoring divider that scales both interval ends by the total,
// forms the new bounds, runs the renormalization scan and emits the code bits
// bit-serially, one bit per cycle when emission is not stalled. A full
// 32-bit word that cannot leave because the output register is still held
// stalls emission until the word is taken. Words are packed first bit in bit 0.
`include "arithmetic_range_encoder_assert.svh"

module arithmetic_range_encoder import are_pkg::*; #(
  parameter int PENDING_MAX = 255
) (
  input logic         clk,
  input logic         rst,
  are_item_if.sink    item,
  are_result_if.source result
);

  localparam int PW = $clog2(PENDING_MAX + 1);
  localparam int BW = PW + 6;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ADJ  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_RESP = 3'd6;

  logic [2:0] state;

  // Coder state.
  logic [CODE_W-1:0]    interval_low;
  logic [CODE_W-1:0]    interval_high;
  logic [PW-1:0]        pending_count;
  logic [WORD_BITS-1:0] word_buffer;
  logic [POS_W-1:0]     bit_position;

  // Arithmetic datapath.
  logic [FREQ_W-1:0] c_r;
  logic [FREQ_W:0]   cs_r;
  logic [FREQ_W-1:0] t_r;
  logic [Q_W-1:0]    rng;
  logic              mul_step;
  logic [FREQ_W:0]   rem_hi;
  logic [FREQ_W:0]   rem_lo;
  logic [Q_W-1:0]    q_hi;
  logic [Q_W-1:0]    q_lo;
  logic [POS_W-1:0]  div_cnt;

  // Renormalization and emission.
  logic [CODE_W-1:0] em_sr;
  logic [POS_W:0]    m_cnt;
  logic              first_done;
  logic              first_bit;
  logic [PW-1:0]     pend_new;
  logic              sat_flag;
  logic [RES_W-1:0]  nres;
  logic [RES_W-1:0]  res_idx;

  // Held single response and the output register.
  logic [WORD_BITS-1:0] resp_word;
  logic [BYTES_W-1:0]   resp_bytes;
  logic [STATUS_W-1:0]  resp_status;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_word;
  logic [BYTES_W-1:0]   out_bytes;
  logic                 out_last;
  logic [STATUS_W-1:0]  out_status;

  // Request decode.
  logic [FREQ_W:0] cs_sum;
  logic            freq_bad;
  logic [Q_W-1:0]  rng_now;

  assign cs_sum   = {1'b0, item.cum_freq} + {1'b0, item.sym_freq};
  assign freq_bad = (item.sym_freq == '0) || (item.total_freq == '0) ||
                    (cs_sum > {1'b0, item.total_freq});
  assign rng_now  = {1'b0, interval_high} + Q_W'(1) - {1'b0, interval_low};

  // One shared multiplier, used for the upper end first, then the lower.
  logic [FREQ_W:0]   mul_b;
  logic [PROD_W-1:0] prod;

  assign mul_b = mul_step ? {1'b0, c_r} : cs_r;
  assign prod  = {{(PROD_W - Q_W){1'b0}}, rng} * {{(PROD_W - FREQ_W - 1){1'b0}}, mul_b};

  // One restoring step per cycle on both quotients.
  logic [FREQ_W+1:0] r2_hi;
  logic [FREQ_W+1:0] r2_lo;
  logic              ge_hi;
  logic              ge_lo;
  logic [FREQ_W+1:0] sub_hi;
  logic [FREQ_W+1:0] sub_lo;

  assign r2_hi  = {rem_hi, q_hi[Q_W-1]};
  assign r2_lo  = {rem_lo, q_lo[Q_W-1]};
  assign ge_hi  = r2_hi >= {2'b00, t_r};
  assign ge_lo  = r2_lo >= {2'b00, t_r};
  assign sub_hi = r2_hi - {2'b00, t_r};
  assign sub_lo = r2_lo - {2'b00, t_r};

  // New bounds from the quotients.
  logic [Q_W-1:0] hi_sum;
  logic [Q_W-1:0] lo_sum;

  assign hi_sum = {1'b0, interval_low} + q_hi - Q_W'(1);
  assign lo_sum = {1'b0, interval_low} + q_lo;

  // Scan conditions.
  logic scan_match;
  logic scan_under;

  assign scan_match = interval_high[CODE_W-1] == interval_low[CODE_W-1];
  assign scan_under = !interval_high[CODE_W-2] && interval_low[CODE_W-2];

  // Number of result words this encode will fill.
  logic [BW-1:0] emit_total;
  logic [BW-1:0] nwords;

  assign emit_total = BW'(bit_position) + BW'(m_cnt) +
                      ((m_cnt != '0) ? BW'(pending_count) : BW'(0));
  assign nwords     = emit_total >> POS_W;

  // Emission: first renormalization bit, then pending bits, then the rest.
  logic                 use_pend;
  logic                 use_sr;
  logic                 emit_bit;
  logic                 bval;
  logic                 word_full;
  logic                 push;
  logic                 out_free;
  logic                 go;
  logic                 load_out;
  logic [WORD_BITS-1:0] filled;
  logic [STATUS_W-1:0]  item_status;

  assign use_pend    = first_done && (pending_count != '0);
  assign use_sr      = !use_pend && (m_cnt != '0);
  assign emit_bit    = use_pend || use_sr;
  assign bval        = use_pend ? ~first_bit : em_sr[CODE_W-1];
  assign word_full   = bit_position == POS_W'(WORD_BITS - 1);
  assign push        = emit_bit && word_full && (res_idx < nres);
  assign out_free    = !out_valid || result.ready;
  assign go          = emit_bit && (!push || out_free);
  assign filled      = word_buffer | (WORD_BITS'(bval) << bit_position);
  assign item_status = sat_flag ? STATUS_SAT : STATUS_OK;

  // The output register takes a new word or a held response this cycle.
  assign load_out = ((state == ST_EMIT) && go && push) ||
                    ((state == ST_RESP) && out_free);

  assign item.ready         = state == ST_IDLE;
  assign result.valid       = out_valid;
  assign result.out_word    = out_word;
  assign result.valid_bytes = out_bytes;
  assign result.last_of_run = out_last;
  assign result.status      = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      interval_low  <= '0;
      interval_high <= '1;
      pending_count <= '0;
      word_buffer   <= '0;
      bit_position  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            if (item.req_type == REQ_FLUSH) begin
              resp_word    <= word_buffer;
              resp_bytes   <= BYTES_W'(({1'b0, bit_position} + (POS_W + 1)'(7)) >> 3);
              resp_status  <= STATUS_OK;
              word_buffer  <= '0;
              bit_position <= '0;
              state        <= ST_RESP;
            end else if (freq_bad) begin
              resp_word   <= '0;
              resp_bytes  <= '0;
              resp_status <= STATUS_BAD;
              state       <= ST_RESP;
            end else begin
              c_r      <= item.cum_freq;
              cs_r     <= cs_sum;
              t_r      <= item.total_freq;
              rng      <= rng_now;
              mul_step <= 1'b0;
              state    <= ST_MUL;
            end
          end
        end

        ST_MUL: begin
          // The quotient fits in Q_W bits, so the top of the product is
          // already below the total and seeds the remainder.
          mul_step <= 1'b1;
          div_cnt  <= '0;
          if (!mul_step) begin
            rem_hi <= prod[PROD_W-1:Q_W];
            q_hi   <= prod[Q_W-1:0];
          end else begin
            rem_lo <= prod[PROD_W-1:Q_W];
            q_lo   <= prod[Q_W-1:0];
            state  <= ST_DIV;
          end
        end

        ST_DIV: begin
          rem_hi  <= ge_hi ? sub_hi[FREQ_W:0] : r2_hi[FREQ_W:0];
          rem_lo  <= ge_lo ? sub_lo[FREQ_W:0] : r2_lo[FREQ_W:0];
          q_hi    <= {q_hi[Q_W-2:0], ge_hi};
          q_lo    <= {q_lo[Q_W-2:0], ge_lo};
          div_cnt <= div_cnt + POS_W'(1);
          if (div_cnt == POS_W'(DIV_STEPS - 1)) begin
            state <= ST_ADJ;
          end
        end

        ST_ADJ: begin
          interval_high <= hi_sum[CODE_W-1:0];
          interval_low  <= lo_sum[CODE_W-1:0];
          em_sr         <= lo_sum[CODE_W-1:0];
          m_cnt         <= '0;
          pend_new      <= pending_count;
          sat_flag      <= 1'b0;
          first_done    <= 1'b0;
          res_idx       <= '0;
          state         <= ST_SCAN;
        end

        ST_SCAN: begin
          if (scan_match) begin
            interval_high <= {interval_high[CODE_W-2:0], 1'b1};
            interval_low  <= {interval_low[CODE_W-2:0], 1'b0};
            m_cnt         <= m_cnt + (POS_W + 1)'(1);
            pend_new      <= '0;
          end else if (scan_under) begin
            // Keep the top bit and drop the second one.
            interval_high <= {1'b1, interval_high[CODE_W-3:0], 1'b1};
            interval_low  <= {1'b0, interval_low[CODE_W-3:0], 1'b0};
            if (pend_new >= PW'(PENDING_MAX)) begin
              sat_flag <= 1'b1;
            end else begin
              pend_new <= pend_new + PW'(1);
            end
          end else begin
            nres  <= (nwords > BW'(MAX_RESULTS)) ? RES_W'(MAX_RESULTS) : nwords[RES_W-1:0];
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (!emit_bit) begin
            pending_count <= pend_new;
            resp_word     <= '0;
            resp_bytes    <= '0;
            resp_status   <= STATUS_SAT;
            state         <= (sat_flag && (nres == '0)) ? ST_RESP : ST_IDLE;
          end else if (go) begin
            if (use_pend) begin
              pending_count <= pending_count - PW'(1);
            end else begin
              em_sr      <= {em_sr[CODE_W-2:0], 1'b0};
              m_cnt      <= m_cnt - (POS_W + 1)'(1);
              first_done <= 1'b1;
              if (!first_done) begin
                first_bit <= em_sr[CODE_W-1];
              end
            end
            bit_position <= bit_position + POS_W'(1);
            word_buffer  <= word_full ? '0 : filled;
            if (push) begin
              out_word   <= filled;
              out_bytes  <= BYTES_W'(WORD_BITS / 8);
              out_last   <= res_idx == RES_W'(nres - RES_W'(1));
              out_status <= item_status;
              res_idx    <= res_idx + RES_W'(1);
            end
          end
        end

        ST_RESP: begin
          if (out_free) begin
            out_word   <= resp_word;
            out_bytes  <= resp_bytes;
            out_last   <= 1'b1;
            out_status <= resp_status;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // After the scan the interval straddles the midpoint.
  `ARE_ASSERT_HOLDS(a_emit_straddles, state == ST_EMIT, interval_high[CODE_W-1] && !interval_low[CODE_W-1], "interval does not straddle the midpoint during emission")
  // A saturated request leaves the pending count pinned at its limit.
  `ARE_ASSERT_HOLDS(a_sat_pinned, sat_flag && (state == ST_SCAN || state == ST_EMIT), pend_new == PW'(PENDING_MAX), "saturation flagged below the pending limit")
  // A flush request empties the packer.
  `ARE_ASSERT_NEXT(a_flush_clears, item.valid && item.ready && item.req_type == REQ_FLUSH, bit_position == '0 && word_buffer == '0, "flush did not clear the packer")

endmodule
